@@ rtl/core/sad_pkg.sv @@
// ----------------------------------------------------------------------------
// sad_pkg
// constants and tables for the standard atmosphere density pipeline
// ----------------------------------------------------------------------------
package sad_pkg;

  localparam int DENSITY_FRAC_BITS = 22;

  localparam int ALT_W  = 17;
  localparam int DENS_W = 24;
  localparam int LOG_STEPS = 30;
  localparam int EXP_STEPS = 8;

  localparam logic signed [ALT_W-1:0] ALT_TOP  = 17'sd47000;
  localparam logic signed [ALT_W-1:0] ALT_L1   = 17'sd11000;
  localparam logic signed [ALT_W-1:0] ALT_L2   = 17'sd20000;
  localparam logic signed [ALT_W-1:0] ALT_L3   = 17'sd32000;

  localparam logic [1:0] LAY_TROPO = 2'd0;
  localparam logic [1:0] LAY_ISO   = 2'd1;
  localparam logic [1:0] LAY_STR1  = 2'd2;
  localparam logic [1:0] LAY_STR2  = 2'd3;

  // temperatures in units of 1e-4 K
  localparam logic [21:0] TB_L0  = 22'd2881500;
  localparam logic [21:0] TB_ISO = 22'd2166500;
  localparam logic [21:0] TB_L3  = 22'd2286500;

  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  localparam logic [29:0] EXP_TAB [EXP_STEPS] = '{
    30'd759250125, 30'd902905651, 30'd984625594, 30'd1028218693,
    30'd1050733751, 30'd1062175491, 30'd1067942999, 30'd1070842298
  };

  localparam logic [32:0] RHO_BASE [4] = '{
    33'd5261336298, 33'd1563038103, 33'd378117170, 33'd56803497
  };

  localparam logic [29:0] E0_Q24 = 30'd71400937;
  localparam logic [29:0] E2_Q24 = 30'd589935212;
  localparam logic [29:0] E3_Q24 = 30'd221476500;
  localparam logic [27:0] C1_Q40 = 28'd250132353;

endpackage

@@ rtl/core/standard_atmosphere_density_unit.sv @@
// ----------------------------------------------------------------------------
// standard_atmosphere_density_unit
// air density of the four-layer standard atmosphere, pipelined
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  input   | in_altitude_m                           | start, busy
//  result  | out_density_q, out_out_of_range         | out_valid strobe
//
//  one item enters every cycle; busy is always low
//  out_valid rises once the item has passed the 30 squaring stages of the
//  log2 unit, the 8 table stages of the exp2 unit and the final multiply
//  and round stages
//  rst_n clears the valid bits only; the receiver cannot stall the pipeline
// ----------------------------------------------------------------------------
module standard_atmosphere_density_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [sad_pkg::ALT_W-1:0]       in_altitude_m,
  output logic                                   out_valid,
  output logic        [sad_pkg::DENS_W-1:0]      out_density_q,
  output logic                                   out_out_of_range
);
  import sad_pkg::*;

  localparam int NL = LOG_STEPS;
  localparam int NE = EXP_STEPS;

  // one squaring step of the log2 mantissa: {fraction bit, next mantissa}
  function automatic logic [32:0] log_step(input logic [31:0] m);
    logic [63:0] sq;
    logic [32:0] t;
    sq = 64'(m) * 64'(m);
    t  = sq[63:31];
    return t[32] ? {1'b1, t[32:1]} : {1'b0, t[31:0]};
  endfunction

  assign busy = 1'b0;

  // ---------------- input stage ----------------
  logic               acc;
  logic               oor_c;
  logic [1:0]         lay_c;
  logic [ALT_W-1:0]   dfull_c;
  logic [13:0]        d_c;
  logic [21:0]        tq_c, tb_c;

  assign acc = start & ~busy;

  always_comb begin
    oor_c = (in_altitude_m < 0) || (in_altitude_m > ALT_TOP);
    if (in_altitude_m <= ALT_L1) begin
      lay_c = LAY_TROPO; dfull_c = in_altitude_m;
    end else if (in_altitude_m <= ALT_L2) begin
      lay_c = LAY_ISO;   dfull_c = in_altitude_m - ALT_L1;
    end else if (in_altitude_m <= ALT_L3) begin
      lay_c = LAY_STR1;  dfull_c = in_altitude_m - ALT_L2;
    end else begin
      lay_c = LAY_STR2;  dfull_c = in_altitude_m - ALT_L3;
    end
    d_c = dfull_c[13:0];
    case (lay_c)
      LAY_TROPO: begin tb_c = TB_L0;  tq_c = TB_L0 - 22'(d_c) * 22'd65; end
      LAY_ISO:   begin tb_c = TB_ISO; tq_c = TB_ISO; end
      LAY_STR1:  begin tb_c = TB_ISO; tq_c = TB_ISO + 22'(d_c) * 22'd10; end
      default:   begin tb_c = TB_L3;  tq_c = TB_L3 + 22'(d_c) * 22'd28; end
    endcase
  end

  // ---------------- log2 stages ----------------
  // temperatures in range all have their leading one at bit 21, so the
  // integer parts cancel and only the fraction bits are kept
  logic        lg_vld_r [NL+1];
  logic        lg_oor_r [NL+1];
  logic [1:0]  lg_lay_r [NL+1];
  logic [13:0] lg_d_r   [NL+1];
  logic [31:0] lg_mt_r  [NL+1];
  logic [31:0] lg_mb_r  [NL+1];
  logic [29:0] lg_ft_r  [NL+1];
  logic [29:0] lg_fb_r  [NL+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_vld_r[0] <= 1'b0;
    end else begin
      lg_vld_r[0] <= acc;
    end
  end

  always_ff @(posedge clk) begin
    lg_oor_r[0] <= oor_c;
    lg_lay_r[0] <= lay_c;
    lg_d_r[0]   <= d_c;
    lg_mt_r[0]  <= {tq_c, 10'b0};
    lg_mb_r[0]  <= {tb_c, 10'b0};
    lg_ft_r[0]  <= '0;
    lg_fb_r[0]  <= '0;
  end

  for (genvar i = 1; i <= NL; i++) begin : g_log
    logic [32:0] st, sb;
    assign st = log_step(lg_mt_r[i-1]);
    assign sb = log_step(lg_mb_r[i-1]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lg_vld_r[i] <= 1'b0;
      end else begin
        lg_vld_r[i] <= lg_vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      lg_oor_r[i] <= lg_oor_r[i-1];
      lg_lay_r[i] <= lg_lay_r[i-1];
      lg_d_r[i]   <= lg_d_r[i-1];
      lg_mt_r[i]  <= st[31:0];
      lg_mb_r[i]  <= sb[31:0];
      lg_ft_r[i]  <= lg_ft_r[i-1] | (30'(st[32]) << (NL - i));
      lg_fb_r[i]  <= lg_fb_r[i-1] | (30'(sb[32]) << (NL - i));
    end
  end

  // ---------------- log difference ----------------
  logic        df_vld_r, df_oor_r;
  logic [1:0]  df_lay_r;
  logic [29:0] df_diff_r;
  logic [35:0] df_iso_r;
  logic [29:0] diff_c;
  logic [41:0] iso_c;

  always_comb begin
    if (lg_lay_r[NL] == LAY_TROPO) begin
      diff_c = (lg_fb_r[NL] > lg_ft_r[NL]) ? lg_fb_r[NL] - lg_ft_r[NL] : '0;
    end else begin
      diff_c = (lg_ft_r[NL] > lg_fb_r[NL]) ? lg_ft_r[NL] - lg_fb_r[NL] : '0;
    end
    iso_c = 42'(lg_d_r[NL]) * 42'(C1_Q40);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      df_vld_r <= 1'b0;
    end else begin
      df_vld_r <= lg_vld_r[NL];
    end
  end

  always_ff @(posedge clk) begin
    df_oor_r  <= lg_oor_r[NL];
    df_lay_r  <= lg_lay_r[NL];
    df_diff_r <= diff_c;
    df_iso_r  <= 36'(iso_c[41:10]);
  end

  // ---------------- exponent L, then 2^-frac(L) table stages ----------------
  logic        ex_vld_r [NE+1];
  logic        ex_oor_r [NE+1];
  logic [1:0]  ex_lay_r [NE+1];
  logic [5:0]  ex_int_r [NE+1];
  logic [29:0] ex_f_r   [NE+1];
  logic [30:0] ex_m_r   [NE+1];
  logic [29:0] ecoef_c;
  logic [59:0] lprod_c;
  logic [35:0] l_c;

  always_comb begin
    case (df_lay_r)
      LAY_TROPO: ecoef_c = E0_Q24;
      LAY_STR1:  ecoef_c = E2_Q24;
      default:   ecoef_c = E3_Q24;
    endcase
    lprod_c = 60'(df_diff_r) * 60'(ecoef_c);
    l_c = (df_lay_r == LAY_ISO) ? df_iso_r : lprod_c[59:24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_vld_r[0] <= 1'b0;
    end else begin
      ex_vld_r[0] <= df_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    ex_oor_r[0] <= df_oor_r;
    ex_lay_r[0] <= df_lay_r;
    ex_int_r[0] <= l_c[35:30];
    ex_f_r[0]   <= l_c[29:0];
    ex_m_r[0]   <= Q30_ONE;
  end

  for (genvar j = 1; j <= NE; j++) begin : g_exp
    logic [60:0] pm;
    assign pm = 61'(ex_m_r[j-1]) * 61'(EXP_TAB[j-1]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ex_vld_r[j] <= 1'b0;
      end else begin
        ex_vld_r[j] <= ex_vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      ex_oor_r[j] <= ex_oor_r[j-1];
      ex_lay_r[j] <= ex_lay_r[j-1];
      ex_int_r[j] <= ex_int_r[j-1];
      ex_f_r[j]   <= ex_f_r[j-1];
      ex_m_r[j]   <= ex_f_r[j-1][29-(j-1)] ? pm[60:30] : ex_m_r[j-1];
    end
  end

  // ---------------- cubic for the low fraction bits, beside the table ----------------
  logic [21:0] px1_r, px2a_r, px3a_r;
  logic [13:0] px2_r, px2b_r;
  logic [5:0]  px3_r;
  logic [30:0] pp_r [4:NE];
  logic [51:0] rx_c;
  logic [43:0] sq_c;
  logic [35:0] cu_c;
  logic [11:0] div6_c;
  logic [31:0] p_c;

  always_comb begin
    rx_c   = 52'(ex_f_r[0][21:0]) * 52'(LN2_Q30);
    sq_c   = 44'(px1_r) * 44'(px1_r);
    cu_c   = 36'(px2_r) * 36'(px2a_r);
    // x3 stays below 64, where times 43 over 256 is exact floor of v/6
    div6_c = 12'(px3_r) * 12'd43;
    p_c    = 32'(Q30_ONE) - 32'(px3a_r) + 32'(px2b_r[13:1]) - 32'(div6_c[11:8]);
  end

  always_ff @(posedge clk) begin
    px1_r  <= rx_c[51:30];
    px2_r  <= sq_c[43:30];
    px2a_r <= px1_r;
    px3_r  <= cu_c[35:30];
    px3a_r <= px2a_r;
    px2b_r <= px2_r;
    pp_r[4] <= p_c[30:0];
  end

  for (genvar k = 5; k <= NE; k++) begin : g_pcarry
    always_ff @(posedge clk) begin
      pp_r[k] <= pp_r[k-1];
    end
  end

  // ---------------- factor, product, round, shift ----------------
  logic        fc_vld_r, fc_oor_r, pr_vld_r, pr_oor_r, rd_vld_r, rd_oor_r, rd_big_r;
  logic [1:0]  fc_lay_r;
  logic [5:0]  fc_int_r, pr_int_r;
  logic [5:0]  rd_s_r;
  logic [30:0] fc_fac_r;
  logic [63:0] pr_prod_r;
  logic [64:0] rd_sum_r;
  logic [61:0] fp_c;
  logic [6:0]  s_c;
  logic [64:0] sh_c;

  assign fp_c = 62'(ex_m_r[NE]) * 62'(pp_r[NE]);
  assign s_c  = 7'(62 - DENSITY_FRAC_BITS) + 7'(pr_int_r);
  assign sh_c = rd_sum_r >> rd_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_vld_r  <= 1'b0;
      pr_vld_r  <= 1'b0;
      rd_vld_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      fc_vld_r  <= ex_vld_r[NE];
      pr_vld_r  <= fc_vld_r;
      rd_vld_r  <= pr_vld_r;
      out_valid <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    fc_oor_r  <= ex_oor_r[NE];
    fc_lay_r  <= ex_lay_r[NE];
    fc_int_r  <= ex_int_r[NE];
    fc_fac_r  <= fp_c[60:30];
    pr_oor_r  <= fc_oor_r;
    pr_int_r  <= fc_int_r;
    pr_prod_r <= 64'(RHO_BASE[fc_lay_r]) * 64'(fc_fac_r);
    rd_oor_r  <= pr_oor_r;
    rd_big_r  <= s_c[6];
    rd_s_r    <= s_c[5:0];
    rd_sum_r  <= 65'(pr_prod_r) + (65'd1 << (s_c - 7'd1));
    out_out_of_range <= rd_oor_r;
    if (rd_oor_r || rd_big_r) begin
      out_density_q <= '0;
    end else if (|sh_c[64:DENS_W]) begin
      out_density_q <= '1;
    end else begin
      out_density_q <= sh_c[DENS_W-1:0];
    end
  end

endmodule

@@ rtl/core/sad_checker.sv @@
// ----------------------------------------------------------------------------
// sad_checker
// port-level checks for the standard atmosphere density unit
// ----------------------------------------------------------------------------
module sad_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic signed [sad_pkg::ALT_W-1:0]  in_altitude_m,
  input logic                              out_valid,
  input logic        [sad_pkg::DENS_W-1:0] out_density_q,
  input logic                              out_out_of_range
);
  import sad_pkg::*;

  // LAT is the distance from the accepting edge to the edge that samples the strobe
  localparam int LAT = 45;

  // every accepted item gives exactly one strobe, at distance LAT
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result strobe missing");

  a_nospur: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without an item");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |-> (out_density_q == '0))
    else $error("fault with nonzero density");

  a_fault_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (($signed($past(in_altitude_m, LAT)) > ALT_TOP) ||
                   ($signed($past(in_altitude_m, LAT)) < 0)))
      |-> out_out_of_range)
    else $error("out of range altitude not flagged");

endmodule

bind standard_atmosphere_density_unit sad_checker u_sad_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .in_altitude_m(in_altitude_m), .out_valid(out_valid),
  .out_density_q(out_density_q), .out_out_of_range(out_out_of_range)
);

@@ dv/density_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// density_checker
// watches both channels of the density unit, predicts each result from the
// accepted altitude and compares it field by field with what comes out
// ----------------------------------------------------------------------------
module density_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic signed [sad_pkg::ALT_W-1:0]  in_altitude_m,
  input  logic                              out_valid,
  input  logic        [sad_pkg::DENS_W-1:0] out_density_q,
  input  logic                              out_out_of_range,
  output int                                errors,
  output int                                pending,
  output int                                results_seen
);
  import sad_pkg::*;

  typedef struct packed {
    logic [DENS_W-1:0] density;
    logic              oor;
  } density_res_t;

  density_res_t expected_density_q[$];

  localparam longint unsigned DENS_SAT = 64'd16777215;

  function automatic longint unsigned log2_fixed(input logic [31:0] x);
    int unsigned n;
    longint unsigned m;
    longint unsigned res;
    n = 0;
    if (x == 0) return 0;
    while (n < 31 && (x >> (n + 1)) != 0) n++;
    m = longint'(x) << (31 - n);
    res = longint'(n) << 30;
    for (int i = 1; i <= LOG_STEPS; i++) begin
      m = (m * m) >> 31;
      if (m >= 64'd4294967296) begin
        m = m >> 1;
        res = res | (64'd1 << (30 - i));
      end
    end
    return res;
  endfunction

  function automatic longint unsigned pow2_neg_frac(input longint unsigned f);
    longint unsigned m, r, x, x2, x3, p;
    m = 64'd1073741824;
    for (int i = 0; i < EXP_STEPS; i++) begin
      if ((f >> (29 - i)) & 64'd1) m = (m * longint'(EXP_TAB[i])) >> 30;
    end
    r = f & 64'd4194303;
    x = (r * longint'(LN2_Q30)) >> 30;
    x2 = (x * x) >> 30;
    x3 = (x2 * x) >> 30;
    p = 64'd1073741824 - x + x2 / 2 - x3 / 6;
    return (m * p) >> 30;
  endfunction

  function automatic density_res_t predict_density(input logic signed [ALT_W-1:0] alt_in);
    int alt;
    longint unsigned big_l, d, lt, lb, diff, fac, prod, dens, e;
    logic [31:0] tq, tb;
    logic [1:0] layer;
    int unsigned s;
    density_res_t r;
    alt = int'(alt_in);
    if (alt < 0 || alt > 47000) begin
      r.density = '0;
      r.oor = 1'b1;
      return r;
    end
    if (alt <= 11000) begin
      layer = LAY_TROPO; d = 64'(alt); tb = 32'(TB_L0); tq = tb - 32'(65 * d);
    end else if (alt <= 20000) begin
      layer = LAY_ISO; d = 64'(alt - 11000); tb = 32'(TB_ISO); tq = tb;
    end else if (alt <= 32000) begin
      layer = LAY_STR1; d = 64'(alt - 20000); tb = 32'(TB_ISO); tq = tb + 32'(10 * d);
    end else begin
      layer = LAY_STR2; d = 64'(alt - 32000); tb = 32'(TB_L3); tq = tb + 32'(28 * d);
    end
    if (layer == LAY_ISO) begin
      big_l = (d * longint'(C1_Q40)) >> 10;
    end else begin
      lt = log2_fixed(tq);
      lb = log2_fixed(tb);
      if (layer == LAY_TROPO) begin
        diff = (lb > lt) ? lb - lt : 0;
        big_l = (diff * longint'(E0_Q24)) >> 24;
      end else begin
        diff = (lt > lb) ? lt - lb : 0;
        e = (layer == LAY_STR1) ? longint'(E2_Q24) : longint'(E3_Q24);
        big_l = (diff * e) >> 24;
      end
    end
    fac = pow2_neg_frac(big_l & 64'd1073741823);
    prod = longint'(RHO_BASE[layer]) * fac;
    s = 62 + int'(big_l >> 30) - DENSITY_FRAC_BITS;
    // shift too long gives zero, else round half up
    if (s >= 64) dens = 0;
    else dens = (prod + (64'd1 << (s - 1))) >> s;
    if (dens > DENS_SAT) dens = DENS_SAT;
    r.density = dens[DENS_W-1:0];
    r.oor = 1'b0;
    return r;
  endfunction

  initial begin
    errors = 0;
    results_seen = 0;
  end

  assign pending = expected_density_q.size();

  always @(posedge clk) begin
    density_res_t exp_r;
    if (rst_n) begin
      if (start && !busy) expected_density_q.push_back(predict_density(in_altitude_m));
      if (out_valid) begin
        results_seen++;
        if (expected_density_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result density %0d oor %0b", $time,
                   out_density_q, out_out_of_range);
        end else begin
          exp_r = expected_density_q.pop_front();
          if (out_density_q !== exp_r.density) begin
            errors++;
            $display("%0t: density expected %0d actual %0d", $time, exp_r.density,
                     out_density_q);
          end
          if (out_out_of_range !== exp_r.oor) begin
            errors++;
            $display("%0t: out_of_range expected %0b actual %0b", $time, exp_r.oor,
                     out_out_of_range);
          end
        end
      end
    end
  end
endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives altitudes into the density unit with and without input gaps and
// gives the verdict from the checker's error and pending counts
// ----------------------------------------------------------------------------
module tb;
  import sad_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [ALT_W-1:0] in_altitude_m = '0;
  logic out_valid;
  logic [DENS_W-1:0] out_density_q;
  logic out_out_of_range;
  int errors, pending, results_seen;
  int idle_pct;
  int items_sent;
  int quiet_cycles;

  always #5 clk = ~clk;

  standard_atmosphere_density_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_altitude_m(in_altitude_m), .out_valid(out_valid),
    .out_density_q(out_density_q), .out_out_of_range(out_out_of_range)
  );

  density_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_altitude_m(in_altitude_m), .out_valid(out_valid),
    .out_density_q(out_density_q), .out_out_of_range(out_out_of_range),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  // cycles with no item accepted and no result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_altitude(input logic signed [ALT_W-1:0] alt);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_altitude_m <= alt;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic signed [ALT_W-1:0] rand_altitude();
    int k;
    k = $urandom_range(99);
    if (k < 70) return ALT_W'($urandom_range(47000));
    if (k < 80) return ALT_W'(47000 + $urandom_range(4) - 2);
    if (k < 85) return ALT_W'($urandom_range(3) * 1000 * 11 + $urandom_range(2));
    return ALT_W'($urandom);
  endfunction

  initial begin
    int directed[$];
    quiet_cycles = 0;
    items_sent = 0;
    idle_pct = 0;
    directed = '{-65536, -1, 0, 1, 5000, 10999, 11000, 11001, 15000, 19999, 20000,
                 20001, 25000, 31999, 32000, 32001, 40000, 46999, 47000, 47001,
                 65535, 4096, 32768, -32768};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_altitude(ALT_W'(directed[i]));
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 65 : (ph == 3) ? 32 : 0;
      repeat (190) send_altitude(rand_altitude());
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d altitudes over all four layers and both out-of-range sides,",
             items_sent);
    $display("with gapless and gapped input; %0d results compared", results_seen);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

@@ standard_atmosphere_density_unit.f @@
rtl/core/sad_pkg.sv
rtl/core/standard_atmosphere_density_unit.sv
rtl/core/sad_checker.sv
dv/density_checker.sv
dv/tb.sv
